/* design/smk_pkg.sv */
`default_nettype none

package smk_pkg;

   localparam int DEF_MAX_ENTRIES = 32;
   localparam int DEF_MAX_LEN = 32;

   localparam logic [5:0] ENTRY_COUNT_RESET = 6'd19;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_MATCH = 1'b1;

   localparam logic [7:0] NAME_END = 8'h00;

   typedef enum logic [1:0] {
      MS_SEARCHING = 2'd0,
      MS_MATCHED = 2'd1,
      MS_NO_MATCH = 2'd2
   } match_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOWER,
      ST_UPPER,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic read;
      logic tok_load;
      logic lo_shift;
      logic hi_shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* design/smk_req_if.sv */
`default_nettype none

interface smk_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [4:0] entry_index;
   logic [4:0] char_position;
   logic [7:0] char_value;
   logic       first_char;

   modport source(output valid, req_type, entry_index, char_position, char_value, first_char,
                  input ready);
   modport sink(input valid, req_type, entry_index, char_position, char_value, first_char,
                output ready);
endinterface

`default_nettype wire

/* design/smk_rsp_if.sv */
`default_nettype none

interface smk_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] match_status;
   logic [4:0] match_index;

   modport source(output valid, match_status, match_index, input ready);
   modport sink(input valid, match_status, match_index, output ready);
endinterface

`default_nettype wire

/* design/smk_cell.sv */
`default_nettype none

// one table entry: its bytes, the byte under the cursor, and one place of each bound token
module smk_cell
   import smk_pkg::*;
#(
   parameter int MAX_LEN = DEF_MAX_LEN,
   localparam int LW = $clog2(MAX_LEN)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          wr_en,
   input  wire logic [LW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [LW-1:0] rd_addr,
   input  wire logic [7:0]    key,
   input  wire logic          set_lo,
   input  wire logic          set_hi,
   input  wire logic          lo_prev,
   input  wire logic          hi_next,
   output logic               tok_lo,
   output logic               tok_hi,
   output logic               hit_lt,
   output logic               hit_gt
);

   logic [7:0] mem [MAX_LEN];
   logic [7:0] rdata_ff;
   logic       tok_lo_ff, tok_lo_in;
   logic       tok_hi_ff, tok_hi_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.read) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      tok_lo_in = tok_lo_ff;
      tok_hi_in = tok_hi_ff;
      if (ctrl.tok_load) begin
         tok_lo_in = set_lo;
         tok_hi_in = set_hi;
      end else begin
         if (ctrl.lo_shift) begin
            tok_lo_in = lo_prev;
         end
         if (ctrl.hi_shift) begin
            tok_hi_in = hi_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_lo_ff <= 1'b0;
         tok_hi_ff <= 1'b0;
      end else begin
         tok_lo_ff <= tok_lo_in;
         tok_hi_ff <= tok_hi_in;
      end
   end

   assign tok_lo = tok_lo_ff;
   assign tok_hi = tok_hi_ff;
   assign hit_lt = tok_lo_ff && (rdata_ff < key);
   assign hit_gt = tok_hi_ff && (rdata_ff > key);

endmodule

`default_nettype wire

/* design/sorted_keyword_matcher.sv */
// Sorted keyword matcher.
// req_chan (valid/ready): a beat with req_type load writes one table byte
// (entry_index, char_position, char_value) and gives no result.
// A beat with req_type match streams one request byte; first_char starts a
// new request. Each active request byte gives one rsp_chan beat with
// match_status (searching, matched, no match) and match_index.
// csr_we/csr_wdata write entry_count, sampled when a request starts.
// A request byte passes through ST_READ (every entry read at the cursor), ST_LOWER
// and ST_UPPER (each bound steps over entries that sort below or above the byte)
// and ST_RESULT; the next beat is taken once the result is loaded into the
// output register.
// The bounds are tokens that step through the row of entry cells
// one cell per cycle; one byte of every entry is read in a single cycle.
// A byte is taken while the previous result still waits in the output
// register; a new result stalls the block only if that register is full.
// Reset clears the search (as a fresh request) and sets entry_count to 19;
// table contents are not cleared and must be written before use.
`default_nettype none

module sorted_keyword_matcher
   import smk_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int MAX_LEN = DEF_MAX_LEN
) (
   input  wire logic       clock,
   input  wire logic       reset,
   smk_req_if.sink         req_chan,
   smk_rsp_if.source       rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [5:0] csr_wdata
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int LW = $clog2(MAX_LEN);
   localparam int RST_COUNT = (int'(ENTRY_COUNT_RESET) > MAX_ENTRIES) ? MAX_ENTRIES
                                                                     : int'(ENTRY_COUNT_RESET);
   localparam logic [IW-1:0] RST_UPPER = IW'(RST_COUNT - 1);
   localparam logic [LW-1:0] LAST_POS = LW'(MAX_LEN - 1);

   state_type        state_ff, state_in;
   logic [5:0]       csr_ff;
   logic [IW-1:0]    lower_ff, lower_in;
   logic [IW-1:0]    upper_ff, upper_in;
   logic [IW-1:0]    upper_init;
   logic [LW-1:0]    cursor_ff, cursor_in;
   logic             done_ff, done_in;
   logic [7:0]       char_ff, char_in;
   match_status_type res_status_ff, res_status_in;
   logic [4:0]       res_index_ff, res_index_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [4:0]       rsp_index_ff, rsp_index_in;

   cell_ctrl_type    ctrl;
   logic             req_acc;
   logic             load_wr;
   logic [LW-1:0]    wr_addr;
   logic [MAX_ENTRIES-1:0] tok_lo, tok_hi, hit_lt, hit_gt;
   logic [MAX_ENTRIES-1:0] tok_lo_chain, tok_hi_chain;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign load_wr = req_acc && (req_chan.req_type == REQ_LOAD)
                    && (int'(req_chan.char_position) < MAX_LEN);
   assign wr_addr = LW'(req_chan.char_position);

   always_comb begin
      if (csr_ff == 6'd0) begin
         upper_init = '0;
      end else if (int'(csr_ff) > MAX_ENTRIES) begin
         upper_init = IW'(MAX_ENTRIES - 1);
      end else begin
         upper_init = IW'(int'(csr_ff) - 1);
      end
   end

   assign tok_lo_chain = {tok_lo[MAX_ENTRIES-2:0], 1'b0};
   assign tok_hi_chain = {1'b0, tok_hi[MAX_ENTRIES-1:1]};

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      smk_cell #(.MAX_LEN(MAX_LEN)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .wr_en     (load_wr && (int'(req_chan.entry_index) == i)),
         .wr_addr   (wr_addr),
         .wr_data   (req_chan.char_value),
         .rd_addr   (cursor_ff),
         .key       (char_ff),
         .set_lo    (lower_ff == IW'(i)),
         .set_hi    (upper_ff == IW'(i)),
         .lo_prev   (tok_lo_chain[i]),
         .hi_next   (tok_hi_chain[i]),
         .tok_lo    (tok_lo[i]),
         .tok_hi    (tok_hi[i]),
         .hit_lt    (hit_lt[i]),
         .hit_gt    (hit_gt[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      cursor_in = cursor_ff;
      done_in = done_ff;
      char_in = char_ff;
      res_status_in = res_status_ff;
      res_index_in = res_index_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_chan.req_type == REQ_MATCH)) begin
               char_in = req_chan.char_value;
               if (req_chan.first_char) begin
                  lower_in = '0;
                  upper_in = upper_init;
                  cursor_in = '0;
                  done_in = 1'b0;
                  state_in = ST_READ;
               end else if (!done_ff) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ctrl.read = 1'b1;
            ctrl.tok_load = 1'b1;
            state_in = ST_LOWER;
         end
         ST_LOWER: begin
            if (|hit_lt) begin
               if (lower_ff == upper_ff) begin
                  res_status_in = MS_NO_MATCH;
                  res_index_in = '0;
                  done_in = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  lower_in = lower_ff + 1'b1;
                  ctrl.lo_shift = 1'b1;
               end
            end else begin
               state_in = ST_UPPER;
            end
         end
         ST_UPPER: begin
            res_index_in = '0;
            if (|hit_gt) begin
               if (upper_ff == lower_ff) begin
                  res_status_in = MS_NO_MATCH;
                  done_in = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  upper_in = upper_ff - 1'b1;
                  ctrl.hi_shift = 1'b1;
               end
            end else begin
               state_in = ST_RESULT;
               if (char_ff == NAME_END) begin
                  res_status_in = MS_MATCHED;
                  res_index_in = 5'(lower_ff);
                  done_in = 1'b1;
               end else if (cursor_ff == LAST_POS) begin
                  res_status_in = MS_NO_MATCH;
                  done_in = 1'b1;
               end else begin
                  res_status_in = MS_SEARCHING;
                  cursor_in = cursor_ff + 1'b1;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in = res_index_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         csr_ff <= ENTRY_COUNT_RESET;
         lower_ff <= '0;
         upper_ff <= RST_UPPER;
         cursor_ff <= '0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         lower_ff <= lower_in;
         upper_ff <= upper_in;
         cursor_ff <= cursor_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      res_status_ff <= res_status_in;
      res_index_ff <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.match_status = rsp_status_ff;
   assign rsp_chan.match_index = rsp_index_ff;

`ifndef ASSERT_OFF
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOWER || state_ff == ST_UPPER) |-> (lower_ff <= upper_ff))
      else $error("lower bound passed upper bound during scan");

   a_lo_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOWER || state_ff == ST_UPPER) |-> $onehot(tok_lo))
      else $error("lower token not one-hot");

   a_hi_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOWER || state_ff == ST_UPPER) |-> $onehot(tok_hi))
      else $error("upper token not one-hot");

   a_lo_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOWER) |-> (tok_lo[lower_ff] == 1'b1))
      else $error("lower token does not match lower bound");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && rsp_valid_ff && !rsp_chan.ready) |=> (state_ff == ST_RESULT))
      else $error("result dropped while output register full");
`endif

endmodule

`default_nettype wire
